// ===== src/sli_pkg.sv =====
// Shared types and constants for the sorted list insert/delete block.
// No dependencies; used by sli_cell and sorted_list_insert_delete.
package sli_pkg;

   localparam int LIST_DEPTH    = 16;
   localparam int VALUE_W       = 32;
   localparam int CNT_W         = $clog2(LIST_DEPTH + 1);
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 5;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // Broadcast to every cell in the row.
   typedef struct packed {
      logic                      update;
      op_type                    op;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic signed [VALUE_W-1:0] entry;
      logic                      valid;
      logic                      less;
   } link_type;

endpackage

// ===== src/sli_cell.sv =====
// One slot of the sorted row: holds an entry and its valid flag.
// Depends on sli_pkg.
module sli_cell
   import sli_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  link_type left_link,
   input  link_type right_link,
   input  logic     hit_in,
   output logic     hit_out,
   output link_type link
);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      valid_ff, valid_in;
   logic                      less;
   logic                      match;

   assign less    = valid_ff && (entry_ff < cmd.value);
   assign match   = valid_ff && (entry_ff == cmd.value);
   assign hit_out = hit_in || match;

   assign link.entry = entry_ff;
   assign link.valid = valid_ff;
   assign link.less  = less;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      case (cmd.op)
         OP_INSERT: begin
            // hold below the insert point, take the new value at it, shift up above it
            if (!less) begin
               if (left_link.less) begin
                  entry_in = cmd.value;
                  valid_in = 1'b1;
               end else begin
                  entry_in = left_link.entry;
                  valid_in = left_link.valid;
               end
            end
         end
         OP_DELETE: begin
            // from the first match on, pull the right neighbor down
            if (hit_out) begin
               entry_in = right_link.entry;
               valid_in = right_link.valid;
            end
         end
         default: begin
            entry_in = entry_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.update) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ===== src/sorted_list_insert_delete.sv =====
// Top level of the sorted list insert/delete block: a row of sli_cell slots,
// the entry counter and the result register. Depends on sli_pkg and sli_cell.
//
// Holds up to LIST_DEPTH signed 32-bit values in ascending order in a row of
// cells, one value per cell. An insert goes ahead of the first entry that is
// not smaller (so ahead of equal entries); a delete removes the first equal
// entry. Every cell compares against the item value at once and takes its own
// value, its left neighbor's or its right neighbor's, so the whole list
// updates at the clock edge at which the item is accepted, one item per cycle
// while results drain; the result shows in the cycle after. The result sits
// in an output register; a new item is taken whenever that register is empty
// or is being emptied in the same cycle. Each result carries the status (done,
// not found, full), the entry count after the item and the smallest entry,
// which reads as zero with smallest_valid low when the list is empty.
module sorted_list_insert_delete
   import sli_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_opcode,
   input  logic signed [VALUE_W-1:0]       req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic [ENTRY_COUNT_W-1:0]        rsp_entry_count,
   output logic signed [VALUE_W-1:0]       rsp_smallest_value,
   output logic                            rsp_smallest_valid
);

   logic                    accept;
   logic                    full;
   logic                    found;
   cmd_type                 cmd;
   link_type                links [LIST_DEPTH];
   link_type                left_links [LIST_DEPTH];
   link_type                right_links [LIST_DEPTH];
   logic [LIST_DEPTH:0]     hit_chain;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff;
   status_type              status_ff, status_in;

   // take a new item when the result register is free or draining now
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(LIST_DEPTH));

   assign cmd.op     = op_type'(req_opcode);
   assign cmd.value  = req_value;
   // drop the update on an insert into a full list
   assign cmd.update = accept && !((cmd.op == OP_INSERT) && full);

   assign hit_chain[0] = 1'b0;
   assign found        = hit_chain[LIST_DEPTH];

   genvar gi;
   generate
      for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
         // cell zero sees a left neighbor that is always smaller
         if (gi == 0) begin : g_left_edge
            assign left_links[gi] = '{entry: '0, valid: 1'b1, less: 1'b1};
         end else begin : g_left_inner
            assign left_links[gi] = links[gi-1];
         end
         // past the last cell an empty slot shifts in on delete
         if (gi == LIST_DEPTH - 1) begin : g_right_edge
            assign right_links[gi] = '{entry: '0, valid: 1'b0, less: 1'b0};
         end else begin : g_right_inner
            assign right_links[gi] = links[gi+1];
         end

         sli_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .left_link  (left_links[gi]),
            .right_link (right_links[gi]),
            .hit_in     (hit_chain[gi]),
            .hit_out    (hit_chain[gi+1]),
            .link       (links[gi])
         );
      end
   endgenerate

   // count and status follow the operation
   always_comb begin
      count_in  = count_ff;
      status_in = ST_DONE;
      case (cmd.op)
         OP_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (found) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: begin
            count_in  = count_ff;
            status_in = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
   end

   // list state only moves on accept, so these hold while the result stalls
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_entry_count    = ENTRY_COUNT_W'(count_ff);
   assign rsp_smallest_valid = links[0].valid;
   assign rsp_smallest_value = links[0].valid ? links[0].entry : '0;

endmodule
